/* design/fbsc_pkg.sv */
// Shared types, widths and codes for the frustum box/sphere cull block.
package fbsc_pkg;

    localparam int NUM_PLANES_DEF = 6;
    localparam int REG_COUNT      = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int PLANE_W        = 64;
    localparam int COORD_W        = 16;
    localparam int RADIUS_W       = 15;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int DIST_W         = PROD_W + 2;
    localparam int FRAC_SHIFT     = 14;
    localparam int VIS_W          = 2;
    localparam int S_TDATA_W      = 160;
    localparam int M_TDATA_W      = 8;

    localparam logic CMD_BOX    = 1'b0;
    localparam logic CMD_SPHERE = 1'b1;

    localparam logic [VIS_W-1:0] VIS_OUTSIDE = 2'd0;
    localparam logic [VIS_W-1:0] VIS_INSIDE  = 2'd1;
    localparam logic [VIS_W-1:0] VIS_CROSS   = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // load enables of the three stages inside a plane lane
    typedef struct packed {
        logic mul;
        logic add;
        logic sgn;
    } stage_en_t;

endpackage

/* design/fbsc_lane.sv */
// One plane lane: corner select, products, partial sums and sign test.
module fbsc_lane import fbsc_pkg::*; (
    input  logic                aclk,
    input  logic [PLANE_W-1:0]  plane,
    input  logic                sphere,
    input  point_t              hi,
    input  point_t              lo,
    input  point_t              center,
    input  logic [RADIUS_W-1:0] radius,
    input  stage_en_t           en,
    output logic                far_behind,
    output logic                near_behind
);

    coord_t a, b, c, d;
    point_t far_pt, near_pt;
    logic signed [DIST_W-1:0] off_far, off_near;

    logic signed [PROD_W-1:0] far_px_reg, far_py_reg, far_pz_reg;
    logic signed [PROD_W-1:0] near_px_reg, near_py_reg, near_pz_reg;
    logic signed [DIST_W-1:0] off_far_reg, off_near_reg;
    logic signed [DIST_W-1:0] far_s0_reg, far_s1_reg, near_s0_reg, near_s1_reg;
    logic signed [DIST_W-1:0] far_dist, near_dist;
    logic                     far_behind_reg, near_behind_reg;

    assign a = plane[15:0];
    assign b = plane[31:16];
    assign c = plane[47:32];
    assign d = plane[63:48];

    // sign of each normal component picks the corner; a sphere uses its center
    always_comb begin
        if (sphere) begin
            far_pt  = center;
            near_pt = center;
        end else begin
            far_pt.x  = a[COORD_W-1] ? lo.x : hi.x;
            far_pt.y  = b[COORD_W-1] ? lo.y : hi.y;
            far_pt.z  = c[COORD_W-1] ? lo.z : hi.z;
            near_pt.x = a[COORD_W-1] ? hi.x : lo.x;
            near_pt.y = b[COORD_W-1] ? hi.y : lo.y;
            near_pt.z = c[COORD_W-1] ? hi.z : lo.z;
        end
    end

    assign off_near = {{(DIST_W-COORD_W-FRAC_SHIFT){d[COORD_W-1]}}, d,
                       {FRAC_SHIFT{1'b0}}};
    assign off_far  = off_near + (sphere
                      ? {{(DIST_W-RADIUS_W-FRAC_SHIFT){1'b0}}, radius,
                         {FRAC_SHIFT{1'b0}}}
                      : {DIST_W{1'b0}});

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            far_px_reg   <= a * far_pt.x;
            far_py_reg   <= b * far_pt.y;
            far_pz_reg   <= c * far_pt.z;
            near_px_reg  <= a * near_pt.x;
            near_py_reg  <= b * near_pt.y;
            near_pz_reg  <= c * near_pt.z;
            off_far_reg  <= off_far;
            off_near_reg <= off_near;
        end
        if (en.add) begin
            far_s0_reg  <= {{2{far_px_reg[PROD_W-1]}}, far_px_reg}
                         + {{2{far_py_reg[PROD_W-1]}}, far_py_reg};
            far_s1_reg  <= {{2{far_pz_reg[PROD_W-1]}}, far_pz_reg} + off_far_reg;
            near_s0_reg <= {{2{near_px_reg[PROD_W-1]}}, near_px_reg}
                         + {{2{near_py_reg[PROD_W-1]}}, near_py_reg};
            near_s1_reg <= {{2{near_pz_reg[PROD_W-1]}}, near_pz_reg} + off_near_reg;
        end
        if (en.sgn) begin
            far_behind_reg  <= far_dist[DIST_W-1];
            near_behind_reg <= near_dist[DIST_W-1];
        end
    end

    assign far_dist  = far_s0_reg + far_s1_reg;
    assign near_dist = near_s0_reg + near_s1_reg;

    assign far_behind  = far_behind_reg;
    assign near_behind = near_behind_reg;

endmodule

/* design/frustum_box_sphere_cull_top.sv */
// Top level of the frustum box/sphere cull block: config, pipeline control, result.
//
// Usage: write the plane registers (index 0 left, 1 right, 2 bottom, 3 top,
// 4 near, 5 far; a in bits 15:0, b 31:16, c 47:32 as Q2.14, d 63:48 as Q12.4)
// on the cfg channel while the block is idle. Writes to an index at or above
// NUM_PLANES are dropped. Then stream queries on the s_axis channel: tuser
// carries cmd (0 box, 1 sphere), tdata the box corners, sphere center and
// radius. Each query returns one beat on m_axis with the visibility code
// (0 outside, 1 inside, 2 intersecting) in tdata[1:0].
// From accepted input beat to valid output beat a query passes the input register,
// multiply, partial sums, final sum with sign, and result register. Throughput
// is one query per cycle unless m_axis stalls; all NUM_PLANES lanes work in parallel.
// When the receiver stalls, the held result stays stable and earlier stages
// keep filling any empty slots, so input is still taken until every stage
// holds a beat. Reset clears all valid bits and every plane register, after
// which every query answers inside.
module frustum_box_sphere_cull_top import fbsc_pkg::*; #(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PLANE_W-1:0]   cfg_data,
    // query input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata, low bit up: corner_hi_x, corner_hi_y, corner_hi_z, corner_lo_x,
    // corner_lo_y, corner_lo_z, center_x, center_y, center_z, radius, 1 pad bit
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: cmd
    input  logic                 s_axis_tuser,
    // result output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata, low bit up: visibility, 6 pad bits
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // plane registers, only those that take part in a test are kept
    logic [PLANE_W-1:0] plane_reg [NUM_PLANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    plane_reg[i] <= cfg_data;
                end
            end
        end
    end

    // stage valids: 0 input, 1 multiply, 2 partial sums, 3 sign, 4 result
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    // a stage loads when it is empty or its content moves on
    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign s_axis_tready = rdy0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_axis_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // input payload, captured as it arrives
    point_t              hi_reg, lo_reg, center_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic                cmd0_reg, cmd1_reg, cmd2_reg, cmd3_reg;
    logic [VIS_W-1:0]    vis_reg, vis_next;

    always_ff @(posedge aclk) begin
        if (rdy0) begin
            hi_reg.x   <= s_axis_tdata[15:0];
            hi_reg.y   <= s_axis_tdata[31:16];
            hi_reg.z   <= s_axis_tdata[47:32];
            lo_reg.x   <= s_axis_tdata[63:48];
            lo_reg.y   <= s_axis_tdata[79:64];
            lo_reg.z   <= s_axis_tdata[95:80];
            center_reg.x <= s_axis_tdata[111:96];
            center_reg.y <= s_axis_tdata[127:112];
            center_reg.z <= s_axis_tdata[143:128];
            radius_reg <= s_axis_tdata[158:144];
            cmd0_reg   <= s_axis_tuser;
        end
        if (rdy1) cmd1_reg <= cmd0_reg;
        if (rdy2) cmd2_reg <= cmd1_reg;
        if (rdy3) cmd3_reg <= cmd2_reg;
        if (rdy4) vis_reg  <= vis_next;
    end

    stage_en_t lane_en;
    logic [NUM_PLANES-1:0] far_behind, near_behind;

    assign lane_en.mul = rdy1;
    assign lane_en.add = rdy2;
    assign lane_en.sgn = rdy3;

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
        fbsc_lane u_lane (
            .aclk        (aclk),
            .plane       (plane_reg[p]),
            .sphere      (cmd0_reg == CMD_SPHERE),
            .hi          (hi_reg),
            .lo          (lo_reg),
            .center      (center_reg),
            .radius      (radius_reg),
            .en          (lane_en),
            .far_behind  (far_behind[p]),
            .near_behind (near_behind[p])
        );
    end

    // any far corner behind a plane: outside; else any near corner: crossing.
    // A sphere only tests its center plus radius on the far path.
    always_comb begin
        if (|far_behind) begin
            vis_next = VIS_OUTSIDE;
        end else if ((cmd3_reg == CMD_BOX) && (|near_behind)) begin
            vis_next = VIS_CROSS;
        end else begin
            vis_next = VIS_INSIDE;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-VIS_W){1'b0}}, vis_reg};

endmodule
